>>> rtl/core/dotted_quad_ipv4_parser_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dotted-quad IPv4 parser
// Same-cycle-implication and next-cycle-implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef DOTTED_QUAD_IPV4_PARSER_TOP_MACROS_SVH
`define DOTTED_QUAD_IPV4_PARSER_TOP_MACROS_SVH

// same-cycle implication, checked at every clk edge out of reset
`define DQIP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DQIP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/dqip_pkg.sv
// ----------------------------------------------------------------------------
// dqip_pkg
// Character codes, limits and shared types of the dotted-quad IPv4 parser.
// ----------------------------------------------------------------------------
package dqip_pkg;

  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_DIGIT_LO = 8'h30;
  localparam logic [7:0] CH_DIGIT_HI = 8'h39;

  localparam logic [9:0] GROUP_MAX  = 10'd255;
  localparam logic [1:0] MAX_DIGITS = 2'd3;
  localparam logic [1:0] LAST_GROUP = 2'd3;

  typedef logic [7:0] char_t;

  typedef enum logic [2:0] {
    CLS_NUL,
    CLS_BLANK,
    CLS_DIGIT,
    CLS_DOT,
    CLS_OTHER
  } char_class_t;

  // word held in the input register
  typedef struct packed {
    logic  valid;
    char_t character;
  } stage_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] address;
  } result_t;

  function automatic char_class_t classify(char_t c);
    char_class_t cls;
    if (c == CH_NUL)
      cls = CLS_NUL;
    else if (c == CH_SPACE || c == CH_TAB)
      cls = CLS_BLANK;
    else if (c >= CH_DIGIT_LO && c <= CH_DIGIT_HI)
      cls = CLS_DIGIT;
    else if (c == CH_DOT)
      cls = CLS_DOT;
    else
      cls = CLS_OTHER;
    return cls;
  endfunction

endpackage

>>> rtl/core/dqip_in_stage.sv
// ----------------------------------------------------------------------------
// dqip_in_stage
// Input register: holds one accepted character until the parse step takes it.
// ----------------------------------------------------------------------------
module dqip_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  dqip_pkg::char_t in_character,
  input  logic            take,
  output dqip_pkg::stage_t stage
);

  logic            valid_r, valid_nxt;
  dqip_pkg::char_t char_r;

  assign in_ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready)
      valid_nxt = 1'b1;
    else if (take)
      valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      valid_r <= 1'b0;
    else
      valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready)
      char_r <= in_character;
  end

  assign stage.valid     = valid_r;
  assign stage.character = char_r;

endmodule

>>> rtl/core/dqip_step_unit.sv
// ----------------------------------------------------------------------------
// dqip_step_unit
// Parse state and the per-character update; builds the result at the NUL.
// ----------------------------------------------------------------------------
module dqip_step_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  dqip_pkg::stage_t  stage,
  input  logic              out_free,
  output logic              take,
  output logic              res_load,
  output dqip_pkg::result_t res
);

  logic [9:0]  group_value_r, group_value_nxt;
  logic [1:0]  digit_count_r, digit_count_nxt;
  logic        after_dot_r, after_dot_nxt;
  logic [1:0]  group_index_r, group_index_nxt;
  logic [23:0] partial_r, partial_nxt;
  logic        failed_r, failed_nxt;

  dqip_pkg::char_class_t cls;
  logic [9:0]            digit;
  logic [9:0]            times_ten;
  logic                  good;

  assign cls = dqip_pkg::classify(stage.character);
  // a NUL needs room in the result register, anything else goes straight in
  assign take     = stage.valid && (cls != dqip_pkg::CLS_NUL || out_free);
  assign res_load = take && cls == dqip_pkg::CLS_NUL;

  assign digit     = {6'd0, stage.character[3:0]};
  assign times_ten = {group_value_r[6:0], 3'b000} + {group_value_r[8:0], 1'b0};

  assign good = !failed_r && digit_count_r != 2'd0 &&
                group_index_r == dqip_pkg::LAST_GROUP &&
                group_value_r <= dqip_pkg::GROUP_MAX;

  assign res.ok      = good;
  assign res.address = good ? {partial_r, group_value_r[7:0]} : 32'd0;

  always_comb begin
    group_value_nxt = group_value_r;
    digit_count_nxt = digit_count_r;
    after_dot_nxt   = after_dot_r;
    group_index_nxt = group_index_r;
    partial_nxt     = partial_r;
    failed_nxt      = failed_r;
    if (take) begin
      if (cls == dqip_pkg::CLS_NUL) begin
        group_value_nxt = '0;
        digit_count_nxt = '0;
        after_dot_nxt   = 1'b0;
        group_index_nxt = '0;
        partial_nxt     = '0;
        failed_nxt      = 1'b0;
      end else if (!failed_r) begin
        case (cls)
          dqip_pkg::CLS_BLANK: begin
          end
          dqip_pkg::CLS_DIGIT: begin
            after_dot_nxt = 1'b0;
            if (digit_count_r >= dqip_pkg::MAX_DIGITS) begin
              failed_nxt = 1'b1;
            end else begin
              group_value_nxt = times_ten + digit;
              digit_count_nxt = digit_count_r + 2'd1;
            end
          end
          dqip_pkg::CLS_DOT: begin
            if (after_dot_r || group_value_r > dqip_pkg::GROUP_MAX ||
                group_index_r >= dqip_pkg::LAST_GROUP) begin
              failed_nxt = 1'b1;
            end else begin
              partial_nxt     = {partial_r[15:0], group_value_r[7:0]};
              group_index_nxt = group_index_r + 2'd1;
              group_value_nxt = '0;
              digit_count_nxt = '0;
              after_dot_nxt   = 1'b1;
            end
          end
          default: begin
            failed_nxt = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_value_r <= '0;
      digit_count_r <= '0;
      after_dot_r   <= 1'b0;
      group_index_r <= '0;
      partial_r     <= '0;
      failed_r      <= 1'b0;
    end else begin
      group_value_r <= group_value_nxt;
      digit_count_r <= digit_count_nxt;
      after_dot_r   <= after_dot_nxt;
      group_index_r <= group_index_nxt;
      partial_r     <= partial_nxt;
      failed_r      <= failed_nxt;
    end
  end

endmodule

>>> rtl/core/dqip_out_stage.sv
// ----------------------------------------------------------------------------
// dqip_out_stage
// Result register: holds one parse result until the sink takes it.
// ----------------------------------------------------------------------------
module dqip_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_load,
  input  dqip_pkg::result_t res,
  output logic              out_free,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_ok,
  output logic [31:0]       out_address
);

  logic              valid_r, valid_nxt;
  dqip_pkg::result_t res_r;

  assign out_free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (res_load)
      valid_nxt = 1'b1;
    else if (out_ready)
      valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      valid_r <= 1'b0;
    else
      valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (res_load)
      res_r <= res;
  end

  assign out_valid   = valid_r;
  assign out_ok      = res_r.ok;
  assign out_address = res_r.address;

endmodule

>>> rtl/core/dotted_quad_ipv4_parser_top.sv
// ----------------------------------------------------------------------------
// dotted_quad_ipv4_parser_top
// Dotted-decimal IPv4 string parser, one character word per cycle unless stalled.
// ----------------------------------------------------------------------------
// Feed the string one byte per word, ending with a NUL (0x00). The block takes
// one word every cycle unless a NUL waits for room in the result register; the
// parse state update (digit accumulate, dot shift, error latch) is a single
// registered step behind the input register. Only the NUL produces a result
// word: ok and the 32-bit address (first group in the top byte, 0 when not ok),
// loaded into an output register as the NUL leaves the input register; while
// it waits, non-NUL words keep flowing, and only a following NUL stalls until
// the result is taken. After the NUL all state is clear for the next string.
module dotted_quad_ipv4_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_character,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_ok,
  output logic [31:0] out_address
);

  dqip_pkg::stage_t  stage;
  dqip_pkg::result_t res;
  logic              take;
  logic              res_load;
  logic              out_free;

  dqip_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_character (in_character),
    .take         (take),
    .stage        (stage)
  );

  dqip_step_unit u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .stage    (stage),
    .out_free (out_free),
    .take     (take),
    .res_load (res_load),
    .res      (res)
  );

  dqip_out_stage u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_load    (res_load),
    .res         (res),
    .out_free    (out_free),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_ok      (out_ok),
    .out_address (out_address)
  );

endmodule

>>> rtl/core/dqip_checker.sv
// ----------------------------------------------------------------------------
// dqip_checker
// Port-level checks of the parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "dotted_quad_ipv4_parser_top_macros.svh"

module dqip_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_character,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_ok,
  input logic [31:0] out_address
);

  // NUL words taken but not yet delivered as results
  logic [2:0] pending_r, pending_nxt;
  logic       nul_in, res_out;

  assign nul_in  = in_valid && in_ready && in_character == dqip_pkg::CH_NUL;
  assign res_out = out_valid && out_ready;

  always_comb begin
    pending_nxt = pending_r;
    if (nul_in && !res_out)
      pending_nxt = pending_r + 3'd1;
    else if (!nul_in && res_out)
      pending_nxt = pending_r - 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      pending_r <= '0;
    else
      pending_r <= pending_nxt;
  end

  `DQIP_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_ok) && $stable(out_address), "result word changed while stalled")
  `DQIP_ASSERT_IMP(a_fail_zero, out_valid && !out_ok, out_address == 32'd0,
    "failed parse with nonzero address")
  `DQIP_ASSERT_IMP(a_no_stray, out_valid, pending_r != 3'd0 && pending_r <= 3'd2,
    "result without a matching NUL or too many in flight")
  `DQIP_ASSERT_IMP(a_ready_free, !out_valid || out_ready, in_ready,
    "input stalled with the result side free")

endmodule

bind dotted_quad_ipv4_parser_top dqip_checker u_dqip_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_character (in_character),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_ok       (out_ok),
  .out_address  (out_address)
);
